FILE: rtl/core/esw_pkg.sv
package esw_pkg;

	localparam int FRAC_BITS = 8;
	localparam int CRD_W     = 24;
	localparam int DEP_W     = 24;
	localparam int CLR_W     = 8;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 16;
	localparam int HGT_W     = 13;
	localparam int MAX_ROWS  = 4096;
	localparam int RREG_W    = 14;
	localparam int RND_W     = 18;
	localparam int PROD_W    = 2 * CRD_W;
	localparam int IN_DATA_W  = 6 * CRD_W + 3 * CLR_W;
	localparam int OUT_DATA_W = 80;
	localparam int HALF_LSB  = (2 ** FRAC_BITS) / 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HFIRST,
		PH_HSECOND,
		PH_START,
		PH_INNER,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		BS_FETCH,
		BS_MUL,
		BS_LAUNCH,
		BS_DIV,
		BS_EMIT
	} bstate_t;

	typedef struct packed {
		logic                    is_load;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic        [DEP_W-1:0] az;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by;
		logic        [DEP_W-1:0] bz;
		logic        [CLR_W-1:0] red;
		logic        [CLR_W-1:0] green;
		logic        [CLR_W-1:0] blue;
	} item_t;

	typedef struct packed {
		logic        [CLR_W-1:0] blue;
		logic        [CLR_W-1:0] green;
		logic        [CLR_W-1:0] red;
		logic        [DEP_W-1:0] depth;
		logic signed [COL_W-1:0] column;
		logic        [ROW_W-1:0] row;
		logic                    last;
	} point_t;

	// truncate toward zero, then saturate to the column range
	function automatic logic signed [COL_W-1:0] col_of(input logic signed [CRD_W+1:0] x);
		logic signed [CRD_W+1:0] tq;
		logic signed [CRD_W+1:0] mag;
		mag = (x < 0) ? -x : x;
		mag = mag >>> FRAC_BITS;
		tq  = (x < 0) ? -mag : mag;
		if (tq > (CRD_W+2)'(32767))
			return COL_W'(32767);
		else if (tq < -(CRD_W+2)'(32768))
			return -COL_W'(32768);
		else
			return tq[COL_W-1:0];
	endfunction

	// round half away from zero to an integer row
	function automatic logic signed [RND_W-1:0] round_row(input logic signed [CRD_W-1:0] y);
		logic signed [CRD_W+1:0] mag;
		mag = (y < 0) ? -(CRD_W+2)'(y) : (CRD_W+2)'(y);
		mag = (mag + (CRD_W+2)'(HALF_LSB)) >>> FRAC_BITS;
		return (y < 0) ? -mag[RND_W-1:0] : mag[RND_W-1:0];
	endfunction

endpackage

FILE: rtl/core/esw_front.sv
module esw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first_x, first_y, first_depth, second_x, second_y, second_depth, red, green, blue
	input  logic [esw_pkg::IN_DATA_W-1:0] s_tdata,
	// opcode
	input  logic                          s_tuser,
	input  logic                          pop,
	output logic                          head_valid,
	output esw_pkg::item_t                head
);
	import esw_pkg::*;

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	item_t       in_item;
	logic        push;

	always_comb begin
		in_item.is_load = !s_tuser;
		{in_item.blue, in_item.green, in_item.red, in_item.bz, in_item.by, in_item.bx,
		 in_item.az, in_item.ay, in_item.ax} = s_tdata;
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/core/esw_div.sv
module esw_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [esw_pkg::CRD_W-1:0]  divisor,
	input  logic [esw_pkg::PROD_W-1:0] num_x,
	input  logic [esw_pkg::PROD_W-1:0] num_z,
	output logic                       done,
	output logic [esw_pkg::CRD_W-1:0]  quo_x,
	output logic [esw_pkg::CRD_W-1:0]  quo_z
);
	import esw_pkg::*;

	localparam int STEPS = CRD_W;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CRD_W-1:0] dvs_q;
	logic [CRD_W-1:0] rx_q, lx_q, rz_q, lz_q;
	logic [CRD_W-1:0] rx_n, lx_n, rz_n, lz_n;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic logic [2*CRD_W-1:0] div_step(input logic [CRD_W-1:0] rem,
			input logic [CRD_W-1:0] low, input logic [CRD_W-1:0] d);
		logic [CRD_W:0] r2;
		logic           ge;
		r2 = {rem, low[CRD_W-1]};
		ge = (r2 >= {1'b0, d});
		if (ge)
			r2 = r2 - {1'b0, d};
		return {r2[CRD_W-1:0], low[CRD_W-2:0], ge};
	endfunction

	always_comb begin
		{rx_n, lx_n} = div_step(rx_q, lx_q, dvs_q);
		{rz_n, lz_n} = div_step(rz_q, lz_q, dvs_q);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rx_q  <= num_x[PROD_W-1:CRD_W];
			lx_q  <= num_x[CRD_W-1:0];
			rz_q  <= num_z[PROD_W-1:CRD_W];
			lz_q  <= num_z[CRD_W-1:0];
		end else if (busy_q) begin
			rx_q <= rx_n;
			lx_q <= lx_n;
			rz_q <= rz_n;
			lz_q <= lz_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign quo_x = lx_q;
	assign quo_z = lz_q;

endmodule

FILE: rtl/core/esw_back.sv
module esw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  esw_pkg::item_t                 head,
	output logic                           pop,
	input  logic [esw_pkg::HGT_W-1:0]      height,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// row, column, depth, out_red, out_green, out_blue, zero fill
	output logic [esw_pkg::OUT_DATA_W-1:0] m_tdata,
	// last_point
	output logic                           m_tlast
);
	import esw_pkg::*;

	bstate_t st_q, st_n;
	phase_t  phase_q;

	logic signed [CRD_W-1:0]  sx_q, sy_q, ex_q, ey_q;
	logic        [DEP_W-1:0]  sz_q, ez_q;
	logic        [CLR_W-1:0]  red_q, green_q, blue_q;
	logic signed [RREG_W-1:0] cur_q, fin_q;
	logic        [CRD_W-1:0]  t_q;
	logic        [PROD_W-1:0] px_s1, pz_s1;
	logic                     nx_s1, nz_s1, dzero_s1;
	logic                     out_valid_q;
	point_t                   out_q;

	logic slot_free;
	logic do_load, do_simple, grab_t, div_start, do_inner;

	// load classification
	logic [HGT_W-1:0]        h_eff;
	logic signed [RND_W-1:0] hs, s_row, e_row, h_row, fin_min;
	logic                    horiz, swap;
	logic signed [CRD_W-1:0] lsx, lsy, lex, ley;
	logic [DEP_W-1:0]        lsz, lez;
	phase_t                  ld_phase;
	logic signed [RND_W-1:0] ld_cur, ld_fin;

	always_comb begin
		h_eff   = (height > HGT_W'(MAX_ROWS)) ? HGT_W'(MAX_ROWS) : height;
		hs      = RND_W'({1'b0, h_eff});
		horiz   = (head.ay == head.by) && (head.ax != head.bx);
		swap    = head.ay > head.by;
		lsx     = swap ? head.bx : head.ax;
		lsy     = swap ? head.by : head.ay;
		lsz     = swap ? head.bz : head.az;
		lex     = swap ? head.ax : head.bx;
		ley     = swap ? head.ay : head.by;
		lez     = swap ? head.az : head.bz;
		s_row   = round_row(lsy);
		e_row   = round_row(ley);
		h_row   = RND_W'(head.ay >>> FRAC_BITS);
		fin_min = (e_row < hs - RND_W'(1)) ? e_row : hs - RND_W'(1);
		ld_cur  = RND_W'(cur_q);
		ld_fin  = fin_min;
		ld_phase = PH_IDLE;
		if (horiz) begin
			ld_fin = h_row;
			if (head.ay >= 0 && h_row < hs)
				ld_phase = PH_HFIRST;
		end else if (s_row >= hs) begin
			ld_phase = PH_IDLE;
		end else if (s_row >= 0) begin
			ld_cur   = s_row + RND_W'(1);
			ld_phase = PH_START;
		end else begin
			ld_cur = '0;
			if (e_row < 0)
				ld_phase = PH_IDLE;
			else if (fin_min <= 0)
				ld_phase = PH_END;
			else
				ld_phase = PH_INNER;
		end
	end

	// divider operands
	logic signed [CRD_W:0]   dx, dz, dy;
	logic        [CRD_W-1:0] dx_mag, dz_mag;
	logic signed [CRD_W+2:0] t_full;
	logic                    div_done;
	logic [CRD_W-1:0]        qx, qz;

	always_comb begin
		dx     = (CRD_W+1)'(ex_q) - (CRD_W+1)'(sx_q);
		dz     = (CRD_W+1)'({1'b0, ez_q}) - (CRD_W+1)'({1'b0, sz_q});
		dy     = (CRD_W+1)'(ey_q) - (CRD_W+1)'(sy_q);
		dx_mag = (dx < 0) ? CRD_W'(-dx) : CRD_W'(dx);
		dz_mag = (dz < 0) ? CRD_W'(-dz) : CRD_W'(dz);
		t_full = ((CRD_W+3)'(cur_q) <<< FRAC_BITS) - (CRD_W+3)'(sy_q);
	end

	esw_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (dy[CRD_W-1:0]),
		.num_x   (px_s1),
		.num_z   (pz_s1),
		.done    (div_done),
		.quo_x   (qx),
		.quo_z   (qz)
	);

	// point values
	logic signed [CRD_W+1:0] qxs, qzs, x_in, z_in;
	logic [DEP_W-1:0]        z_clamp;
	logic signed [RREG_W-1:0] cur_inc;
	point_t                  pt_simple, pt_inner;
	phase_t                  ph_simple;

	always_comb begin
		qxs = dzero_s1 ? '0 : (nx_s1 ? -(CRD_W+2)'(qx) : (CRD_W+2)'(qx));
		qzs = dzero_s1 ? '0 : (nz_s1 ? -(CRD_W+2)'(qz) : (CRD_W+2)'(qz));
		x_in = (CRD_W+2)'(sx_q) + qxs;
		z_in = (CRD_W+2)'({1'b0, sz_q}) + qzs;
		if (z_in < 0)
			z_clamp = '0;
		else if (z_in > (CRD_W+2)'({DEP_W{1'b1}}))
			z_clamp = '1;
		else
			z_clamp = z_in[DEP_W-1:0];
		cur_inc = cur_q + 1'b1;

		pt_inner.blue   = blue_q;
		pt_inner.green  = green_q;
		pt_inner.red    = red_q;
		pt_inner.depth  = z_clamp;
		pt_inner.column = col_of(x_in);
		pt_inner.row    = cur_q[ROW_W-1:0];
		pt_inner.last   = 1'b0;

		pt_simple.blue  = blue_q;
		pt_simple.green = green_q;
		pt_simple.red   = red_q;
		pt_simple.row   = fin_q[ROW_W-1:0];
		pt_simple.column = col_of((CRD_W+2)'(sx_q));
		pt_simple.depth = sz_q;
		pt_simple.last  = 1'b0;
		ph_simple       = PH_IDLE;
		unique case (phase_q)
			PH_HFIRST: begin
				ph_simple = PH_HSECOND;
			end
			PH_HSECOND, PH_END: begin
				pt_simple.column = col_of((CRD_W+2)'(ex_q));
				pt_simple.depth  = ez_q;
				pt_simple.last   = 1'b1;
				ph_simple        = PH_IDLE;
			end
			PH_START: begin
				pt_simple.row = (sy_q < 0) ? '0 : sy_q[FRAC_BITS +: ROW_W];
				ph_simple     = (cur_q < fin_q) ? PH_INNER : PH_END;
			end
			default: begin
				ph_simple = phase_q;
			end
		endcase
	end

	assign slot_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			BS_FETCH: begin
				if (head_valid && !head.is_load && phase_q == PH_INNER)
					st_n = BS_MUL;
			end
			BS_MUL:    st_n = BS_LAUNCH;
			BS_LAUNCH: st_n = BS_DIV;
			BS_DIV: begin
				if (div_done)
					st_n = BS_EMIT;
			end
			BS_EMIT: begin
				if (slot_free)
					st_n = BS_FETCH;
			end
			default:   st_n = BS_FETCH;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		do_load   = 1'b0;
		do_simple = 1'b0;
		grab_t    = 1'b0;
		div_start = 1'b0;
		do_inner  = 1'b0;
		unique case (st_q)
			BS_FETCH: begin
				if (head_valid) begin
					priority if (head.is_load) begin
						do_load = 1'b1;
						pop     = 1'b1;
					end else if (phase_q == PH_IDLE) begin
						pop = 1'b1;
					end else if (phase_q == PH_INNER) begin
						grab_t = 1'b1;
					end else if (slot_free) begin
						do_simple = 1'b1;
						pop       = 1'b1;
					end
				end
			end
			BS_LAUNCH: div_start = 1'b1;
			BS_EMIT: begin
				if (slot_free) begin
					do_inner = 1'b1;
					pop      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			sx_q    <= lsx;
			sy_q    <= lsy;
			sz_q    <= lsz;
			ex_q    <= lex;
			ey_q    <= ley;
			ez_q    <= lez;
			red_q   <= head.red;
			green_q <= head.green;
			blue_q  <= head.blue;
		end
		if (grab_t)
			t_q <= t_full[CRD_W-1:0];
		if (st_q == BS_MUL) begin
			px_s1    <= dx_mag * t_q;
			pz_s1    <= dz_mag * t_q;
			nx_s1    <= dx < 0;
			nz_s1    <= dz < 0;
			dzero_s1 <= (dy == 0);
		end
		if (do_simple)
			out_q <= pt_simple;
		else if (do_inner)
			out_q <= pt_inner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BS_FETCH;
			phase_q     <= PH_IDLE;
			cur_q       <= '0;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (do_load) begin
				phase_q <= ld_phase;
				cur_q   <= RREG_W'(ld_cur);
				fin_q   <= RREG_W'(ld_fin);
			end else if (do_simple) begin
				phase_q <= ph_simple;
			end else if (do_inner) begin
				cur_q   <= cur_inc;
				phase_q <= (cur_inc >= fin_q) ? PH_END : PH_INNER;
			end
			if (do_simple || do_inner)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = OUT_DATA_W'({out_q.blue, out_q.green, out_q.red, out_q.depth,
		out_q.column, out_q.row});

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == BS_DIV)
		else $error("divider finished outside the wait state");
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_emit_inner: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BS_EMIT |-> phase_q == PH_INNER)
		else $error("inner point finished outside the inner phase");
`endif

endmodule

FILE: rtl/core/edge_scanline_walker_top.sv
// Load item: no result; taken from the input queue once it reaches the head.
// Start, end and horizontal points: registered, one item per cycle unless m_tready stalls.
// Inner points: multiply, shared 24-step radix-2 divider, emit; one at a time.
// Input queue holds two items, so the input side accepts until it is full while a result waits.
// Asynchronous active-low reset clears the queue, the walk (no edge loaded) and
// sets screen_height to 480.
module edge_scanline_walker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// first_x, first_y, first_depth, second_x, second_y, second_depth, red, green, blue
	input  logic [esw_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// row, column, depth, out_red, out_green, out_blue, zero fill
	output logic [esw_pkg::OUT_DATA_W-1:0] m_tdata,
	// last_point
	output logic                           m_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [1:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import esw_pkg::*;

	logic [HGT_W-1:0] height_q;
	logic             head_valid;
	logic             pop;
	item_t            head;

	assign pready = 1'b1;
	assign prdata = 32'({paddr[1:0] & 2'b00, height_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HGT_W'(480);
		end else if (psel && penable && pwrite && pready) begin
			height_q <= pwdata[HGT_W-1:0];
		end
	end

	esw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	esw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.height     (height_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
